// File: rtl/core/swr_pkg.sv
`default_nettype none

package swr_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int TIME_W       = 32;
	localparam int HEAD_W       = 32;
	localparam int IN_W         = 328;
	localparam int OUT_W        = 8;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_REACQ   = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;

	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_STALL   = 2'd1;
	localparam logic [1:0] REG_GAP     = 2'd2;

	localparam logic [15:0] STALL_RESET = 16'd500;
	localparam logic [15:0] GAP_RESET   = 16'd200;

	typedef struct packed {
		logic        enable;
		logic [15:0] stall_ms;
		logic [15:0] gap_ms;
	} cfg_t;

	typedef struct packed {
		logic [3:0] target;
		logic [1:0] action;
	} res_t;

	// next latched channel number above after (1..8), 0 if none
	function automatic logic [3:0] next_chan(logic [7:0] mask, logic [3:0] after);
		logic [3:0] r;
		r = 4'd0;
		for (int c = MAX_CHANNELS; c >= 1; c--) begin
			if (4'(c) > after && mask[c-1]) begin
				r = 4'(c);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/swr_lane.sv
`default_nettype none

module swr_lane
	import swr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic [HEAD_W-1:0] head,
	input  wire logic              online,
	output logic                   rose
);

	logic [HEAD_W-1:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (load) begin
			base_q <= head;
		end
	end

	assign rose = online && (head > base_q);

endmodule

`default_nettype wire

// File: rtl/core/swr_ctrl.sv
`default_nettype none

module swr_ctrl
	import swr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc,
	input  wire cfg_t              cfg,
	input  wire logic [TIME_W-1:0] now,
	input  wire logic [31:0]       block,
	input  wire logic [7:0]        mask,
	input  wire logic [7:0]        rose,
	output res_t                   res,
	output logic                   load_base
);

	logic              started_q;
	logic              tripped_q;
	logic [31:0]       last_block_q;
	logic [TIME_W-1:0] last_adv_q;
	logic [TIME_W-1:0] last_reacq_q;
	logic [3:0]        pending_q;
	logic [7:0]        latched_q;

	logic              moved;
	logic [TIME_W-1:0] since_adv;
	logic [TIME_W-1:0] since_reacq;
	logic              stall_ok;
	logic              gap_ok;
	logic [3:0]        first_ch;
	logic [3:0]        after_first;
	logic [3:0]        after_pend;

	assign moved       = block != last_block_q;
	assign since_adv   = now - last_adv_q;
	assign since_reacq = now - last_reacq_q;
	// a counter change this tick restarts the stall clock at zero
	assign stall_ok    = moved ? (cfg.stall_ms == 16'd0)
	                           : (since_adv >= TIME_W'(cfg.stall_ms));
	assign gap_ok      = since_reacq >= TIME_W'(cfg.gap_ms);
	assign first_ch    = next_chan(latched_q, 4'd0);
	assign after_first = next_chan(latched_q, first_ch);
	assign after_pend  = next_chan(latched_q, pending_q);

	typedef enum logic [2:0] {
		D_IDLE, D_START, D_HOLD, D_RESUME, D_STEP, D_TRIP, D_REBASE
	} dec_t;

	dec_t dec;

	always_comb begin
		if (!cfg.enable) begin
			dec = D_IDLE;
		end else if (!started_q) begin
			dec = D_START;
		end else if (tripped_q) begin
			dec = moved ? D_RESUME : D_HOLD;
		end else if (pending_q != 4'd0 && gap_ok) begin
			dec = D_STEP;
		end else if (stall_ok && (rose != 8'd0)) begin
			dec = D_TRIP;
		end else begin
			dec = D_REBASE;
		end
	end

	always_comb begin
		res.action = ACT_NONE;
		res.target = 4'd0;
		case (dec)
			D_RESUME: begin
				if (first_ch != 4'd0) begin
					res.action = ACT_REACQ;
					res.target = first_ch;
				end
			end
			D_STEP: begin
				res.action = ACT_REACQ;
				res.target = pending_q;
			end
			D_TRIP: begin
				res.action = ACT_CLEAR;
			end
			default: begin
			end
		endcase
	end

	assign load_base = acc && (dec == D_START || dec == D_REBASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			tripped_q    <= 1'b0;
			last_block_q <= '0;
			last_adv_q   <= '0;
			last_reacq_q <= '0;
			pending_q    <= 4'd0;
			latched_q    <= 8'd0;
		end else if (acc) begin
			if (dec == D_START) begin
				started_q    <= 1'b1;
				last_block_q <= block;
				last_adv_q   <= now;
			end else if (dec != D_IDLE && moved) begin
				last_block_q <= block;
				last_adv_q   <= now;
			end
			case (dec)
				D_RESUME: begin
					tripped_q    <= 1'b0;
					last_reacq_q <= now;
					pending_q    <= (first_ch != 4'd0) ? after_first : 4'd0;
				end
				D_STEP: begin
					last_reacq_q <= now;
					pending_q    <= after_pend;
				end
				D_TRIP: begin
					tripped_q <= 1'b1;
					latched_q <= mask;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/stall_watchdog_reacquire.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// s        in         s_tvalid / s_tready    s_tdata: one tick
// m        out        m_tvalid / m_tready    m_tdata: one action
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One tick per cycle while s_tready is high; each gives one registered action.
// All lane compares and the decision settle in the cycle of the input transfer.
// An output register plus a skid register part the sides; s_tready drops only
// while the skid register holds a result. cfg_ready is always high. Reset
// clears all but result data and restores register defaults; no clearing pass.

module stall_watchdog_reacquire
	import swr_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// now_ms[31:0], block_count[63:32], online_mask[71:64],
	// write_head_0[103:72] .. write_head_7[327:296]
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// action[1:0], target_channel[5:2], zero[7:6]
	output logic [OUT_W-1:0]      m_tdata,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [15:0]      cfg_data
);

	localparam logic [7:0] CHAN_MASK = 8'((1 << CHANNELS) - 1);

	cfg_t        cfg_q;
	logic        acc;
	logic [7:0]  mask;
	logic [7:0]  rose;
	logic        load_base;
	res_t        res;

	logic        m_valid_q;
	res_t        m_data_q;
	logic        skid_valid_q;
	res_t        skid_data_q;
	logic        pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable   <= 1'b0;
			cfg_q.stall_ms <= STALL_RESET;
			cfg_q.gap_ms   <= GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE: cfg_q.enable   <= cfg_data[0];
				REG_STALL:  cfg_q.stall_ms <= cfg_data;
				REG_GAP:    cfg_q.gap_ms   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign s_tready = !skid_valid_q;
	assign acc      = s_tvalid && s_tready;
	assign mask     = s_tdata[71:64] & CHAN_MASK;

	genvar g;
	generate
		for (g = 0; g < MAX_CHANNELS; g++) begin : g_lane
			if (g < CHANNELS) begin : g_on
				swr_lane u_lane (
					.clk    (clk),
					.arst_n (arst_n),
					.load   (load_base),
					.head   (s_tdata[72 + HEAD_W*g +: HEAD_W]),
					.online (mask[g]),
					.rose   (rose[g])
				);
			end else begin : g_off
				assign rose[g] = 1'b0;
			end
		end
	endgenerate

	swr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.cfg       (cfg_q),
		.now       (s_tdata[31:0]),
		.block     (s_tdata[63:32]),
		.mask      (mask),
		.rose      (rose),
		.res       (res),
		.load_base (load_base)
	);

	assign pop = m_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q && pop) begin
			m_valid_q    <= 1'b1;
			skid_valid_q <= 1'b0;
		end else if (acc && (!m_valid_q || pop)) begin
			m_valid_q <= 1'b1;
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end else if (pop) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && pop) begin
			m_data_q <= skid_data_q;
		end else if (acc && (!m_valid_q || pop)) begin
			m_data_q <= res;
		end else if (acc) begin
			skid_data_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_data_q.target, m_data_q.action};

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> m_valid_q)
		else $error("skid register full while output register empty");

	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_data_q.action != 2'd3))
		else $error("undefined action code");

	a_clear_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_data_q.action != ACT_REACQ) |-> (m_data_q.target == 4'd0))
		else $error("target set on non-reacquire action");

	a_reacq_target: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_data_q.action == ACT_REACQ) |->
		(m_data_q.target != 4'd0 && 32'(m_data_q.target) <= 32'(CHANNELS)))
		else $error("reacquire target out of channel range");

	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |=> (m_valid_q && $stable(m_data_q)))
		else $error("output result changed while stalled");

endmodule

`default_nettype wire

// File: test/swr_scoreboard_pkg.sv
package swr_scoreboard_pkg;
	import swr_pkg::*;

	// one tick as it travels on s_tdata, now_ms in the lowest bits
	typedef struct packed {
		logic [7:0][31:0] head;
		logic [7:0]       mask;
		logic [31:0]      block;
		logic [31:0]      now_ms;
	} tick_t;

	class action_scoreboard;
		logic        enable;
		logic [15:0] stall_ms;
		logic [15:0] gap_ms;

		bit          started;
		bit          tripped;
		logic [31:0] last_block;
		logic [31:0] last_advance;
		logic [31:0] last_reacq;
		logic [3:0]  pending_ch;
		logic [7:0]  latched;
		logic [31:0] baseline [8];

		res_t        expected_actions [$];
		int          errors;

		function new();
			enable       = 1'b0;
			stall_ms     = STALL_RESET;
			gap_ms       = GAP_RESET;
			started      = 1'b0;
			tripped      = 1'b0;
			last_block   = '0;
			last_advance = '0;
			last_reacq   = '0;
			pending_ch   = '0;
			latched      = '0;
			foreach (baseline[i]) baseline[i] = '0;
			errors       = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				REG_ENABLE: enable   = data[0];
				REG_STALL:  stall_ms = data;
				REG_GAP:    gap_ms   = data;
				default: ;
			endcase
		endfunction

		// lowest latched channel number above after, 0 when none is left
		function logic [3:0] latched_after(logic [3:0] after);
			for (int c = 1; c <= MAX_CHANNELS; c++) begin
				if (c > after && latched[c-1]) return 4'(c);
			end
			return 4'd0;
		endfunction

		function void note_tick(tick_t t);
			res_t        r;
			bit          moved;
			bit          rose;
			logic [31:0] elapsed;
			r.action = ACT_NONE;
			r.target = 4'd0;
			if (enable && !started) begin
				started      = 1'b1;
				last_block   = t.block;
				last_advance = t.now_ms;
				foreach (baseline[i]) baseline[i] = t.head[i];
			end else if (enable) begin
				moved = (t.block != last_block);
				if (moved) begin
					last_block   = t.block;
					last_advance = t.now_ms;
				end
				elapsed = t.now_ms - last_reacq;
				if (tripped) begin
					if (moved) begin
						tripped    = 1'b0;
						pending_ch = latched_after(4'd0);
						last_reacq = t.now_ms;
						if (pending_ch != 4'd0) begin
							r.action   = ACT_REACQ;
							r.target   = pending_ch;
							pending_ch = latched_after(pending_ch);
						end
					end
				end else if (pending_ch != 4'd0 && elapsed >= {16'd0, gap_ms}) begin
					r.action   = ACT_REACQ;
					r.target   = pending_ch;
					pending_ch = latched_after(pending_ch);
					last_reacq = t.now_ms;
				end else begin
					rose = 1'b0;
					for (int i = 0; i < MAX_CHANNELS; i++) begin
						if (t.mask[i] && t.head[i] > baseline[i]) rose = 1'b1;
					end
					elapsed = t.now_ms - last_advance;
					if (rose && elapsed >= {16'd0, stall_ms}) begin
						tripped  = 1'b1;
						latched  = t.mask;
						r.action = ACT_CLEAR;
					end else begin
						foreach (baseline[i]) baseline[i] = t.head[i];
					end
				end
			end
			expected_actions.insert(expected_actions.size(), r);
		endfunction

		function void check_action(logic [OUT_W-1:0] got);
			res_t want;
			res_t seen;
			if (expected_actions.size() == 0) begin
				$error("action transfer with nothing expected: %0h", got);
				errors++;
				return;
			end
			want = expected_actions.pop_front();
			seen = got[5:0];
			if (seen.action !== want.action) begin
				$error("action: expected %0d, got %0d", want.action, seen.action);
				errors++;
			end
			if (seen.target !== want.target) begin
				$error("target_channel: expected %0d, got %0d", want.target, seen.target);
				errors++;
			end
			if (got[7:6] !== 2'b00) begin
				$error("pad: expected 0, got %0d", got[7:6]);
				errors++;
			end
		endfunction

		function int pending();
			return expected_actions.size();
		endfunction
	endclass

endpackage

// File: test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import swr_pkg::*;
	import swr_scoreboard_pkg::*;

	localparam logic [1:0] REG_UNUSED  = 2'd3;
	localparam int         HOLD_CYCLES = 300;
	localparam int         CYCLE_LIMIT = 600000;
	localparam int         PHASES      = 11;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata   = '0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [15:0]       cfg_data  = '0;

	action_scoreboard  sb = new();

	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int cycle_count   = 0;

	// stimulus world: a plausible system evolving tick by tick
	logic [31:0] w_now;
	logic [31:0] w_block;
	logic [7:0]  w_mask;
	logic [31:0] w_head [8];

	stall_watchdog_reacquire dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL stall_watchdog_reacquire");
			$finish;
		end
	end

	// receiver: random back-pressure plus requested long hold-offs
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_action(m_tdata);
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES;
			m_tready    <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	function automatic tick_t world_tick();
		tick_t t;
		t.now_ms = w_now;
		t.block  = w_block;
		t.mask   = w_mask;
		for (int i = 0; i < MAX_CHANNELS; i++) t.head[i] = w_head[i];
		return t;
	endfunction

	task automatic set_heads(input logic [31:0] v);
		for (int i = 0; i < MAX_CHANNELS; i++) w_head[i] = v;
	endtask

	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_tick(t);
	endtask

	// drop valid and wait for every outstanding action
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic next_tick(output tick_t t);
		int span;
		int step;
		if ($urandom_range(99) < 8) begin
			t.now_ms = $urandom;
			t.block  = $urandom;
			t.mask   = 8'($urandom);
			for (int i = 0; i < MAX_CHANNELS; i++) t.head[i] = $urandom;
			return;
		end
		span = (sb.stall_ms > sb.gap_ms) ? int'(sb.stall_ms) : int'(sb.gap_ms);
		case ($urandom_range(19))
			0:       step = 0;
			1, 2:    step = $urandom_range(0, 2 * span + 2);
			default: step = $urandom_range(0, span / 3 + 2);
		endcase
		w_now = w_now + step;
		if ($urandom_range(99) < 25) begin
			if ($urandom_range(3) == 0) w_block = $urandom;
			else w_block = w_block + $urandom_range(1, 4);
		end
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			case ($urandom_range(9))
				0, 1, 2: w_head[i] = w_head[i] + $urandom_range(1, 100);
				3:       w_head[i] = $urandom;
				default: ;
			endcase
		end
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0:       w_mask = 8'hFF;
				1:       w_mask = 8'h00;
				default: w_mask = 8'($urandom);
			endcase
		end
		t = world_tick();
	endtask

	initial begin
		tick_t       t;
		logic        en;
		logic [15:0] stall_v;
		logic [15:0] gap_v;
		int          count;
		int          saved_idle;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled after reset: field extremes must do nothing
		w_now = '1; w_block = '1; w_mask = 8'hFF; set_heads('1);
		send_tick(world_tick());
		w_now = '0; w_block = '0; w_mask = 8'h00; set_heads('0);
		send_tick(world_tick());

		// default stall and gap times, time wraps during the trip
		cfg_write(REG_ENABLE, 16'd1);
		w_now = 32'hFFFF_FF00; w_block = 32'd5; w_mask = 8'hFF; set_heads('0);
		send_tick(world_tick());
		w_now += 100; set_heads(32'd1);
		send_tick(world_tick());
		// head of channel 1 only equal, channel 8 rose
		w_now += 500; w_mask = 8'h81; w_head[7] = 32'd2;
		send_tick(world_tick());
		w_now += 10;
		send_tick(world_tick());
		w_now += 10; w_block = 32'd6;
		send_tick(world_tick());
		// one short of the gap, then exactly the gap
		w_now += 199;
		send_tick(world_tick());
		w_now += 1;
		send_tick(world_tick());
		// heads rise on offline channels only
		w_now += 600; w_mask = 8'h00; set_heads('1);
		send_tick(world_tick());
		w_now += 600; w_mask = 8'hFF;
		send_tick(world_tick());
		w_head[3] = '0;
		send_tick(world_tick());
		w_now += 1000; w_head[3] = 32'd1; w_mask = 8'h08;
		send_tick(world_tick());
		w_block = 32'd7;
		send_tick(world_tick());
		w_now += 1000; w_head[3] = 32'd2;
		send_tick(world_tick());
		// disable while tripped, then resume
		cfg_write(REG_ENABLE, 16'd0);
		w_block = 32'd8;
		send_tick(world_tick());
		cfg_write(REG_ENABLE, 16'd1);
		send_tick(world_tick());

		for (int phase = 0; phase < PHASES; phase++) begin
			en = 1'b1;
			case (phase)
				0: begin stall_v = 16'd20;   gap_v = 16'd5;    end
				1: begin stall_v = 16'd1;    gap_v = 16'hFFFF; end
				2: begin stall_v = 16'd0;    gap_v = 16'd0;    end
				3: begin stall_v = 16'hFFFF; gap_v = 16'd1;    end
				4: begin en = 1'b0; stall_v = 16'($urandom); gap_v = 16'($urandom); end
				5: begin stall_v = 16'd500;  gap_v = 16'd200;  end
				default: begin
					stall_v = 16'($urandom_range(1, 2000));
					gap_v   = 16'($urandom_range(1, 1000));
				end
			endcase
			if (phase < 4) begin
				src_idle_pct = 36; sink_idle_pct = 64;
			end else if (phase < 8) begin
				src_idle_pct = 64; sink_idle_pct = 36;
			end else begin
				src_idle_pct = 0; sink_idle_pct = 0;
			end
			cfg_write(REG_ENABLE, {15'($urandom), en});
			cfg_write(REG_STALL, stall_v);
			cfg_write(REG_GAP, gap_v);
			if (phase == 0) cfg_write(REG_UNUSED, 16'($urandom));

			if ($urandom_range(1) == 0) w_now = $urandom;
			else w_now = 32'hFFFF_0000 + $urandom_range(0, 65535);
			w_block = $urandom;
			w_mask  = 8'($urandom);
			for (int i = 0; i < MAX_CHANNELS; i++) w_head[i] = $urandom_range(0, 1000);

			count = (phase == 4) ? 30 : 130;
			for (int n = 0; n < count; n++) begin
				// long receiver hold-off while the sender keeps pushing
				if ((phase == 5 || phase == 9) && n == 40) begin
					saved_idle = src_idle_pct;
					src_idle_pct = 0;
					hold_requests++;
					for (int k = 0; k < 24; k++) begin
						next_tick(t);
						send_tick(t);
					end
					src_idle_pct = saved_idle;
				end
				next_tick(t);
				send_tick(t);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS stall_watchdog_reacquire");
		end else begin
			$display("FAIL stall_watchdog_reacquire");
		end
		$finish;
	end

endmodule

// File: stall_watchdog_reacquire.f
rtl/core/swr_pkg.sv
rtl/core/swr_lane.sv
rtl/core/swr_ctrl.sv
rtl/core/stall_watchdog_reacquire.sv
test/swr_scoreboard_pkg.sv
test/tb_top.sv
